FILE: src/ipval_pkg.sv
package ipval_pkg;

  typedef enum logic [1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_V4   = 2'd1,
    VERDICT_V6   = 2'd2
  } verdict_e;

  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;

  localparam logic [9:0] V4MaxValue  = 10'd255;
  localparam logic [2:0] V4MaxDigits = 3'd3;
  localparam logic [2:0] V4LastGroup = 3'd3;
  localparam logic [2:0] V6MaxDigits = 3'd4;
  localparam logic [3:0] V6LastGroup = 4'd7;

  // one character as it is applied to the parsers
  typedef struct packed {
    logic       step;
    logic       last;
    logic [7:0] char_code;
  } beat_t;

endpackage

FILE: src/ipval_v4_check.sv
module ipval_v4_check (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ipval_pkg::beat_t beat_i,
  output logic           ok_o
);

  logic [2:0] group_cnt_q, group_cnt_d;
  logic [2:0] digit_cnt_q, digit_cnt_d;
  logic [9:0] value_q, value_d;
  logic       first_zero_q, first_zero_d;
  logic       still_ok_q, still_ok_d;
  logic       is_digit;
  logic [3:0] digit;
  logic [9:0] value_next;

  assign is_digit = (beat_i.char_code >= ipval_pkg::CharZero) &&
                    (beat_i.char_code <= ipval_pkg::CharNine);
  assign digit = beat_i.char_code[3:0];
  assign value_next = {value_q[6:0], 3'b000} + {value_q[8:0], 1'b0} + {6'd0, digit};

  always_comb begin
    group_cnt_d  = group_cnt_q;
    digit_cnt_d  = digit_cnt_q;
    value_d      = value_q;
    first_zero_d = first_zero_q;
    still_ok_d   = still_ok_q;
    if (beat_i.char_code == ipval_pkg::CharDot) begin
      if (digit_cnt_q == 3'd0) still_ok_d = 1'b0;
      if (group_cnt_q != 3'd7) group_cnt_d = group_cnt_q + 3'd1;
      digit_cnt_d  = 3'd0;
      value_d      = 10'd0;
      first_zero_d = 1'b0;
    end else if (is_digit) begin
      if (digit_cnt_q >= ipval_pkg::V4MaxDigits) begin
        still_ok_d = 1'b0;
      end else begin
        if ((digit_cnt_q != 3'd0) && first_zero_q) still_ok_d = 1'b0;
        if ((digit_cnt_q == 3'd0) && (digit == 4'd0)) first_zero_d = 1'b1;
        value_d = value_next;
        if (value_next > ipval_pkg::V4MaxValue) still_ok_d = 1'b0;
      end
      if (digit_cnt_q != 3'd7) digit_cnt_d = digit_cnt_q + 3'd1;
    end else begin
      still_ok_d = 1'b0;
    end
  end

  assign ok_o = still_ok_d && (digit_cnt_d != 3'd0) &&
                (group_cnt_d == ipval_pkg::V4LastGroup);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_cnt_q  <= 3'd0;
      digit_cnt_q  <= 3'd0;
      value_q      <= 10'd0;
      first_zero_q <= 1'b0;
      still_ok_q   <= 1'b1;
    end else if (beat_i.step) begin
      if (beat_i.last) begin
        group_cnt_q  <= 3'd0;
        digit_cnt_q  <= 3'd0;
        value_q      <= 10'd0;
        first_zero_q <= 1'b0;
        still_ok_q   <= 1'b1;
      end else begin
        group_cnt_q  <= group_cnt_d;
        digit_cnt_q  <= digit_cnt_d;
        value_q      <= value_d;
        first_zero_q <= first_zero_d;
        still_ok_q   <= still_ok_d;
      end
    end
  end

endmodule

FILE: src/ipval_v6_check.sv
module ipval_v6_check (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ipval_pkg::beat_t beat_i,
  output logic           ok_o
);

  logic [3:0] group_cnt_q, group_cnt_d;
  logic [2:0] digit_cnt_q, digit_cnt_d;
  logic       still_ok_q, still_ok_d;
  logic       is_hex;

  assign is_hex = ((beat_i.char_code >= ipval_pkg::CharZero) &&
                   (beat_i.char_code <= ipval_pkg::CharNine)) ||
                  ((beat_i.char_code >= ipval_pkg::CharLowA) &&
                   (beat_i.char_code <= ipval_pkg::CharLowF)) ||
                  ((beat_i.char_code >= ipval_pkg::CharUpA) &&
                   (beat_i.char_code <= ipval_pkg::CharUpF));

  always_comb begin
    group_cnt_d = group_cnt_q;
    digit_cnt_d = digit_cnt_q;
    still_ok_d  = still_ok_q;
    if (beat_i.char_code == ipval_pkg::CharColon) begin
      if (digit_cnt_q == 3'd0) still_ok_d = 1'b0;
      if (group_cnt_q != 4'd15) group_cnt_d = group_cnt_q + 4'd1;
      digit_cnt_d = 3'd0;
    end else if (is_hex) begin
      if (digit_cnt_q >= ipval_pkg::V6MaxDigits) still_ok_d = 1'b0;
      if (digit_cnt_q != 3'd7) digit_cnt_d = digit_cnt_q + 3'd1;
    end else begin
      still_ok_d = 1'b0;
    end
  end

  assign ok_o = still_ok_d && (digit_cnt_d != 3'd0) &&
                (group_cnt_d == ipval_pkg::V6LastGroup);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_cnt_q <= 4'd0;
      digit_cnt_q <= 3'd0;
      still_ok_q  <= 1'b1;
    end else if (beat_i.step) begin
      if (beat_i.last) begin
        group_cnt_q <= 4'd0;
        digit_cnt_q <= 3'd0;
        still_ok_q  <= 1'b1;
      end else begin
        group_cnt_q <= group_cnt_d;
        digit_cnt_q <= digit_cnt_d;
        still_ok_q  <= still_ok_d;
      end
    end
  end

endmodule

FILE: src/ip_address_text_validator.sv
// Checks address text, one character per item, against the IPv4 dotted-quad
// and the IPv6 eight-group hex forms at once. Each character is taken into an
// input register and applied from there to both parsers; the item marked
// tlast yields one verdict item (0 neither, 1 IPv4, 2 IPv6) and returns the
// parsers to their start state; its verdict is held in the output register.
// One item per cycle is sustained; the only stall comes from a verdict still
// held in the output register when the next string ends.
module ip_address_text_validator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] char_code
  input  logic       s_axis_tlast_i,  // is_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o   // [1:0] verdict, [7:2] zero
);

  logic                in_valid_q;
  logic [7:0]          in_char_q;
  logic                in_last_q;
  logic                out_valid_q;
  ipval_pkg::verdict_e out_verdict_q, out_verdict_d;
  logic                out_free;
  logic                fire;
  logic                v4_ok, v6_ok;
  ipval_pkg::beat_t    beat;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || fire;

  assign beat.step      = fire;
  assign beat.last      = in_last_q;
  assign beat.char_code = in_char_q;

  ipval_v4_check u_v4 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .ok_o   (v4_ok)
  );

  ipval_v6_check u_v6 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .ok_o   (v6_ok)
  );

  always_comb begin
    priority if (v6_ok) begin
      out_verdict_d = ipval_pkg::VERDICT_V6;
    end else if (v4_ok) begin
      out_verdict_d = ipval_pkg::VERDICT_V4;
    end else begin
      out_verdict_d = ipval_pkg::VERDICT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_last_q) begin
      out_verdict_q <= out_verdict_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_verdict_q};

endmodule
